>>> sv/lts_pkg.sv
`timescale 1ns / 1ps
package lts_pkg;

  // largest tile the line stores hold
  parameter int MAX_COLS = 1024;
  parameter int MAX_ROWS = 1024;

  // raster counters run over the halo ring too, up to MAX + 1
  parameter int LINE_DEPTH = MAX_COLS + 2;
  parameter int COL_CNT_W  = $clog2(MAX_COLS + 2);
  parameter int ROW_CNT_W  = $clog2(MAX_ROWS + 2);

  // fixed field widths
  parameter int CFG_DATA_W = 11;
  parameter int CFG_IDX_W  = 2;
  parameter int IDX_OUT_W  = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS = 2'd1;

  // line store word: bit 1 row r-2, bit 0 row r-1
  parameter int LINE_W = 2;

  // birth and survival counts of the rule
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  typedef logic [8:0] window_t;

endpackage

>>> sv/lts_cell_if.sv
`timescale 1ns / 1ps
interface lts_cell_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink (input valid, input cell_alive, output ready);
endinterface

>>> sv/lts_result_if.sv
`timescale 1ns / 1ps
interface lts_result_if;
  logic                          valid;
  logic                          ready;
  logic                          next_alive;
  logic [lts_pkg::IDX_OUT_W-1:0] cell_row;
  logic [lts_pkg::IDX_OUT_W-1:0] cell_col;
  logic                          last_cell;
  logic                          tile_all_dead;

  modport source (output valid, output next_alive, output cell_row, output cell_col,
                  output last_cell, output tile_all_dead, input ready);
  modport sink (input valid, input next_alive, input cell_row, input cell_col,
                input last_cell, input tile_all_dead, output ready);
endinterface

>>> sv/lts_cfg_if.sv
`timescale 1ns / 1ps
interface lts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lts_pkg::CFG_IDX_W-1:0]  index;
  logic [lts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/lts_ram.sv
`timescale 1ns / 1ps
module lts_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/lts_cell_rule.sv
`timescale 1ns / 1ps
module lts_cell_rule (
  input  lts_pkg::window_t window,
  output logic             next_alive
);
  import lts_pkg::*;

  logic [3:0] nbr_cnt;

  // count the eight neighbours, the centre is bit 4
  always_comb begin
    nbr_cnt = 4'd0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        nbr_cnt = nbr_cnt + {3'd0, window[k]};
      end
    end
  end

  assign next_alive = (nbr_cnt == BIRTH_CNT) ||
                      (window[4] && (nbr_cnt == SURVIVE_CNT));

endmodule

>>> sv/life_tile_generation_step.sv
`timescale 1ns / 1ps
// a cell passes through the stage 1 register and then the output register before it leaves as a result
// throughput: one raster cell per cycle while the result channel is not stalled, set by the single line store port pair
// the output register lets a new cell enter while a result waits to be taken
// reset: tile_rows and tile_cols go to 1024, raster restarts at row 0 column 0
// line store contents are not cleared, rows 0 and 1 of every tile overwrite them
module life_tile_generation_step (
  input logic             clk,
  input logic             rst_n,
  lts_cfg_if.sink         cfg_ch,
  lts_cell_if.sink        in_ch,
  lts_result_if.source    out_ch
);
  import lts_pkg::*;

  localparam int ADDR_W = $clog2(LINE_DEPTH);

  // configuration
  logic [CFG_DATA_W-1:0] tile_rows_r, tile_rows_nxt;
  logic [CFG_DATA_W-1:0] tile_cols_r, tile_cols_nxt;
  logic                  cfg_fire;
  logic [ROW_CNT_W-1:0]  rows_eff;
  logic [COL_CNT_W-1:0]  cols_eff;
  logic [ROW_CNT_W-1:0]  row_last;
  logic [COL_CNT_W-1:0]  col_last;

  // raster position of the next cell to arrive
  logic [ROW_CNT_W-1:0]  row_r, row_nxt;
  logic [COL_CNT_W-1:0]  col_r, col_nxt;
  logic                  in_fire;
  logic                  in_prod;
  logic                  in_last;

  // stage 1: accepted cell waiting for its line store word
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_bit_r;
  logic [ROW_CNT_W-1:0]  s1_row_r;
  logic [COL_CNT_W-1:0]  s1_col_r;
  logic                  s1_prod_r;
  logic                  s1_last_r;
  logic                  s1_adv;

  // window and dead-tile tracking
  window_t               win_r, win_nxt;
  logic                  any_seen_r, any_seen_nxt;
  logic                  rule_alive;

  // line store
  logic [LINE_W-1:0]     ram_rd_data;
  logic                  ram_wr_en;
  logic [LINE_W-1:0]     ram_wr_data;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_alive_r;
  logic [IDX_OUT_W-1:0]  out_row_r;
  logic [IDX_OUT_W-1:0]  out_col_r;
  logic                  out_last_r;
  logic                  out_dead_r;

  // clamp sizes: zero acts as one, oversize saturates
  always_comb begin
    if (tile_rows_r == '0) begin
      rows_eff = ROW_CNT_W'(1);
    end else if (32'(tile_rows_r) > MAX_ROWS) begin
      rows_eff = ROW_CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = ROW_CNT_W'(tile_rows_r);
    end
    if (tile_cols_r == '0) begin
      cols_eff = COL_CNT_W'(1);
    end else if (32'(tile_cols_r) > MAX_COLS) begin
      cols_eff = COL_CNT_W'(MAX_COLS);
    end else begin
      cols_eff = COL_CNT_W'(tile_cols_r);
    end
  end

  // last raster row and column include the far halo
  assign row_last = rows_eff + ROW_CNT_W'(1);
  assign col_last = cols_eff + COL_CNT_W'(1);

  // handshakes, nothing is taken while reset is held
  assign cfg_ch.ready = rst_n;
  assign cfg_fire     = cfg_ch.valid;
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = rst_n && (!s1_valid_r || s1_adv);
  assign in_fire      = in_ch.valid && in_ch.ready;

  // interior cell centred once the window reaches row 2, column 2 of the raster
  assign in_prod = (row_r >= ROW_CNT_W'(2)) && (col_r >= COL_CNT_W'(2));
  assign in_last = (row_r == row_last) && (col_r == col_last);

  // configuration write
  always_comb begin
    tile_rows_nxt = tile_rows_r;
    tile_cols_nxt = tile_cols_r;
    if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_TILE_ROWS: tile_rows_nxt = cfg_ch.data;
        REG_TILE_COLS: tile_cols_nxt = cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // raster counters restart on a size write, advance per accepted cell, wrap after the last halo cell
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_fire && (cfg_ch.index == REG_TILE_ROWS || cfg_ch.index == REG_TILE_COLS)) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_fire) begin
      if (col_r >= col_last) begin
        col_nxt = '0;
        row_nxt = (row_r >= row_last) ? '0 : row_r + ROW_CNT_W'(1);
      end else begin
        col_nxt = col_r + COL_CNT_W'(1);
      end
    end
  end

  // read the column's stored rows as the cell is accepted
  lts_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ADDR_W'(s1_col_r)),
    .wr_data (ram_wr_data),
    .rd_en   (in_fire),
    .rd_addr (ADDR_W'(col_r)),
    .rd_data (ram_rd_data)
  );

  // shift rows down in the column: middle moves to upper, new cell to middle
  assign ram_wr_en   = s1_adv;
  assign ram_wr_data = {ram_rd_data[0], s1_bit_r};

  // window slides by one column, newest column in the top three bits
  assign win_nxt = {s1_bit_r, ram_rd_data[0], ram_rd_data[1], win_r[8:3]};

  lts_cell_rule u_rule (
    .window     (win_nxt),
    .next_alive (rule_alive)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // live tracking clears with the final cell or a size write so the next tile starts clean
  always_comb begin
    any_seen_nxt = any_seen_r;
    if (cfg_fire && (cfg_ch.index == REG_TILE_ROWS || cfg_ch.index == REG_TILE_COLS)) begin
      any_seen_nxt = 1'b0;
    end else if (s1_adv && s1_prod_r) begin
      any_seen_nxt = s1_last_r ? 1'b0 : (any_seen_r | rule_alive);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_prod_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_rows_r <= CFG_DATA_W'(MAX_ROWS);
      tile_cols_r <= CFG_DATA_W'(MAX_COLS);
      row_r       <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      any_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tile_rows_r <= tile_rows_nxt;
      tile_cols_r <= tile_cols_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      s1_valid_r  <= s1_valid_nxt;
      any_seen_r  <= any_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bit_r  <= in_ch.cell_alive;
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_prod_r <= in_prod;
      s1_last_r <= in_last;
    end
    if (s1_adv) begin
      win_r <= win_nxt;
    end
    if (s1_adv && s1_prod_r) begin
      out_alive_r <= rule_alive;
      out_row_r   <= IDX_OUT_W'(s1_row_r - ROW_CNT_W'(2));
      out_col_r   <= IDX_OUT_W'(s1_col_r - COL_CNT_W'(2));
      out_last_r  <= s1_last_r;
      out_dead_r  <= s1_last_r && !(any_seen_r | rule_alive);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.next_alive    = out_alive_r;
  assign out_ch.cell_row      = out_row_r;
  assign out_ch.cell_col      = out_col_r;
  assign out_ch.last_cell     = out_last_r;
  assign out_ch.tile_all_dead = out_dead_r;

  // the final result sits at the far corner of the tile
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_cell |->
      out_ch.cell_col == IDX_OUT_W'(cols_eff - COL_CNT_W'(1)) &&
      out_ch.cell_row == IDX_OUT_W'(rows_eff - ROW_CNT_W'(1)))
    else $error("last result not at tile corner");

  // dead-tile flag only rides on the final result
  a_dead_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.tile_all_dead |-> out_ch.last_cell)
    else $error("tile_all_dead without last_cell");

  // raster position never leaves the halo-padded tile
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= col_last && row_r <= row_last)
    else $error("raster position out of range");

  // line store read and write never hit the same column in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en && in_fire |-> s1_col_r != col_r)
    else $error("line store read and write collide");

endmodule
